[rtl/wfsu_pkg.sv]
// shared constants, codes and item types of the waveform frame sample unpacker
package wfsu_pkg;

  localparam int NUM_BOARDS        = 4;
  localparam int NUM_CARDS         = 4;
  localparam int NUM_CHIPS         = 4;
  localparam int CHANNELS_PER_CHIP = 68;
  localparam int NUM_BUCKETS       = 512;

  localparam int MAX_CH       = 68;
  localparam int CHIP_SLOTS   = 4;
  localparam int NUM_SLOTS    = 16;
  localparam int BITMAP_SIZE  = CHIP_SLOTS * MAX_CH;
  localparam int BITMAP_IDX_W = $clog2(BITMAP_SIZE);
  localparam int MAX_CH_INDEX = 67;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [7:0] FT_PARTIAL = 8'd1;
  localparam logic [7:0] FT_FULL    = 8'd2;

  localparam logic MODE_HEADER = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  localparam logic REG_TWO_PULSE = 1'b0;

  localparam logic [1:0] TRIG_NONE   = 2'd0;
  localparam logic [1:0] TRIG_FIRST  = 2'd1;
  localparam logic [1:0] TRIG_SECOND = 2'd2;

  typedef logic [BITMAP_IDX_W-1:0] bm_idx_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PLACED  = 2'd1,
    KIND_DROPPED = 2'd2
  } kind_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  frame_type;
    logic [1:0]  board_index;
    logic [1:0]  card_index;
    logic [31:0] event_index;
    logic [1:0]  chip;
    logic [6:0]  channel_in;
    logic [8:0]  bucket_in;
    logic [11:0] sample_in;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic        decay_index;
    logic [1:0]  card_out;
    logic [1:0]  chip_out;
    logic [6:0]  channel_out;
    logic [8:0]  bucket_out;
    logic [11:0] sample_out;
    logic        first_in_channel;
  } out_item_t;

endpackage

[rtl/wfsu_apb.sv]
// configuration register file with apb-style access
module wfsu_apb (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [wfsu_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [wfsu_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [wfsu_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready,
  output logic                           two_pulse_mode
);

  logic two_pulse_r;
  logic two_pulse_nxt;
  logic reg_index;
  logic wr_en;

  assign reg_index  = cfg_paddr[2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    two_pulse_nxt = two_pulse_r;
    if (wr_en && reg_index == wfsu_pkg::REG_TWO_PULSE) begin
      two_pulse_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      two_pulse_r <= 1'b0;
    end else begin
      two_pulse_r <= two_pulse_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (reg_index)
      wfsu_pkg::REG_TWO_PULSE: cfg_prdata = {{(wfsu_pkg::CFG_DATA_W-1){1'b0}}, two_pulse_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  assign two_pulse_mode = two_pulse_r;

endmodule

[rtl/wfsu_proc.sv]
// frame and sample state with single-pass result logic
module wfsu_proc (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  wfsu_pkg::in_item_t  item,
  input  logic                two_pulse_mode,
  output wfsu_pkg::out_item_t result
);

  logic [1:0]  trig_r   [wfsu_pkg::NUM_SLOTS];
  logic [1:0]  trig_nxt [wfsu_pkg::NUM_SLOTS];
  logic [6:0]  ccnt_r   [wfsu_pkg::CHIP_SLOTS];
  logic [6:0]  ccnt_nxt [wfsu_pkg::CHIP_SLOTS];
  logic [9:0]  bcnt_r   [wfsu_pkg::CHIP_SLOTS];
  logic [9:0]  bcnt_nxt [wfsu_pkg::CHIP_SLOTS];
  logic [wfsu_pkg::BITMAP_SIZE-1:0] fired_r, fired_nxt;
  logic [31:0] event_r, event_nxt;
  logic        seen_r, seen_nxt;
  logic        hits_r, hits_nxt;
  logic [7:0]  ftype_r, ftype_nxt;
  logic [1:0]  card_r, card_nxt;
  logic        decay_r, decay_nxt;

  logic [3:0]  slot;
  logic        clr_trig;
  logic [1:0]  slot_trig;
  logic        hdr_ok;
  logic        frame_ok;
  logic        part_ok;
  logic [6:0]  cc;
  logic [9:0]  bc;
  logic [6:0]  ch0;
  logic [9:0]  bk1;
  logic [6:0]  place_ch;
  wfsu_pkg::bm_idx_t bm_idx;
  logic        place;

  assign slot      = {item.board_index, item.card_index};
  assign clr_trig  = seen_r && (item.event_index != event_r) && hits_r;
  assign slot_trig = clr_trig ? wfsu_pkg::TRIG_NONE : trig_r[slot];
  assign hdr_ok    = (item.frame_type == wfsu_pkg::FT_PARTIAL ||
                      item.frame_type == wfsu_pkg::FT_FULL) &&
                     (32'(item.board_index) < wfsu_pkg::NUM_BOARDS) &&
                     (32'(item.card_index) < wfsu_pkg::NUM_CARDS);
  assign frame_ok  = (ftype_r == wfsu_pkg::FT_PARTIAL || ftype_r == wfsu_pkg::FT_FULL) &&
                     (32'(item.chip) < wfsu_pkg::NUM_CHIPS);
  assign part_ok   = (32'(item.channel_in) <= wfsu_pkg::MAX_CH_INDEX) &&
                     (32'(item.channel_in) < wfsu_pkg::CHANNELS_PER_CHIP) &&
                     (32'(item.bucket_in) < wfsu_pkg::NUM_BUCKETS);

  // full readout counters: channel wrap steps the bucket
  assign cc  = ccnt_r[item.chip];
  assign bc  = bcnt_r[item.chip];
  assign ch0 = (32'(cc) >= wfsu_pkg::CHANNELS_PER_CHIP) ? 7'd0 : cc;
  assign bk1 = ((32'(cc) >= wfsu_pkg::CHANNELS_PER_CHIP) &&
                (32'(bc) < wfsu_pkg::NUM_BUCKETS)) ? bc + 10'd1 : bc;

  assign place_ch = (ftype_r == wfsu_pkg::FT_PARTIAL) ? item.channel_in : ch0;
  assign bm_idx   = wfsu_pkg::bm_idx_t'({7'd0, item.chip} * 9'(wfsu_pkg::MAX_CH)) +
                    wfsu_pkg::bm_idx_t'(place_ch);

  always_comb begin
    trig_nxt  = trig_r;
    ccnt_nxt  = ccnt_r;
    bcnt_nxt  = bcnt_r;
    fired_nxt = fired_r;
    event_nxt = event_r;
    seen_nxt  = seen_r;
    hits_nxt  = hits_r;
    ftype_nxt = ftype_r;
    card_nxt  = card_r;
    decay_nxt = decay_r;
    place     = 1'b0;
    result    = '0;
    result.kind        = wfsu_pkg::KIND_DROPPED;
    result.decay_index = decay_r;
    result.card_out    = card_r;

    if (item.mode == wfsu_pkg::MODE_HEADER) begin
      // new frame
      if (clr_trig) begin
        hits_nxt = 1'b0;
        for (int i = 0; i < wfsu_pkg::NUM_SLOTS; i++) begin
          trig_nxt[i] = wfsu_pkg::TRIG_NONE;
        end
      end
      event_nxt = item.event_index;
      seen_nxt  = 1'b1;
      fired_nxt = '0;
      for (int i = 0; i < wfsu_pkg::CHIP_SLOTS; i++) begin
        ccnt_nxt[i] = '0;
        bcnt_nxt[i] = '0;
      end
      card_nxt  = item.card_index;
      decay_nxt = 1'b0;
      if (!hdr_ok) begin
        ftype_nxt = '0;
      end else begin
        ftype_nxt   = item.frame_type;
        result.kind = wfsu_pkg::KIND_HEADER;
        if (two_pulse_mode) begin
          if (slot_trig != wfsu_pkg::TRIG_NONE) begin
            trig_nxt[slot] = wfsu_pkg::TRIG_SECOND;
            decay_nxt      = 1'b1;
          end else begin
            trig_nxt[slot] = wfsu_pkg::TRIG_FIRST;
          end
        end else begin
          trig_nxt[slot] = wfsu_pkg::TRIG_NONE;
        end
      end
      result.decay_index = decay_nxt;
      result.card_out    = item.card_index;
    end else if (frame_ok) begin
      if (ftype_r == wfsu_pkg::FT_PARTIAL) begin
        if (part_ok) begin
          place             = 1'b1;
          result.channel_out = item.channel_in;
          result.bucket_out  = item.bucket_in;
        end
      end else begin
        ccnt_nxt[item.chip] = ch0;
        bcnt_nxt[item.chip] = bk1;
        if (32'(bk1) >= wfsu_pkg::NUM_BUCKETS) begin
          // bucket overflow
          bcnt_nxt[item.chip] = 10'(wfsu_pkg::NUM_BUCKETS);
          ccnt_nxt[item.chip] = '0;
        end else begin
          place               = 1'b1;
          ccnt_nxt[item.chip] = ch0 + 7'd1;
          result.channel_out  = ch0;
          result.bucket_out   = bk1[8:0];
        end
      end
      if (place) begin
        result.kind             = wfsu_pkg::KIND_PLACED;
        result.chip_out         = item.chip;
        result.sample_out       = item.sample_in;
        result.first_in_channel = ~fired_r[bm_idx];
        fired_nxt[bm_idx]       = 1'b1;
        hits_nxt                = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < wfsu_pkg::NUM_SLOTS; i++) begin
        trig_r[i] <= wfsu_pkg::TRIG_NONE;
      end
      for (int i = 0; i < wfsu_pkg::CHIP_SLOTS; i++) begin
        ccnt_r[i] <= '0;
        bcnt_r[i] <= '0;
      end
      fired_r <= '0;
      event_r <= '0;
      seen_r  <= 1'b0;
      hits_r  <= 1'b0;
      ftype_r <= '0;
      card_r  <= '0;
      decay_r <= 1'b0;
    end else if (fire) begin
      trig_r  <= trig_nxt;
      ccnt_r  <= ccnt_nxt;
      bcnt_r  <= bcnt_nxt;
      fired_r <= fired_nxt;
      event_r <= event_nxt;
      seen_r  <= seen_nxt;
      hits_r  <= hits_nxt;
      ftype_r <= ftype_nxt;
      card_r  <= card_nxt;
      decay_r <= decay_nxt;
    end
  end

endmodule

[rtl/waveform_frame_sample_unpacker.sv]
// top level of the waveform frame sample unpacker
// an accepted request is held in the input register, then its result in the result register
// throughput: one request per cycle, one result per request, full rate under no stall
// in_tready follows the result register: it drops only while both stages hold requests and out_tready is low
// reset (synchronous, active low) clears the frame state, counters, trigger map,
// fired bitmap and the two-pulse register
module waveform_frame_sample_unpacker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // frame_type[7:0], board_index[9:8], card_index[11:10], event_index[43:12],
  // chip[45:44], channel_in[52:46], bucket_in[61:53], sample_in[73:62], zero pad
  input  logic [wfsu_pkg::IN_TDATA_W-1:0]  in_tdata,
  // mode[0]
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // decay_index[0], card_out[2:1], chip_out[4:3], channel_out[11:5],
  // bucket_out[20:12], sample_out[32:21], first_in_channel[33], zero pad
  output logic [wfsu_pkg::OUT_TDATA_W-1:0] out_tdata,
  // kind[1:0]
  output logic [1:0]                      out_tuser,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [wfsu_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [wfsu_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [wfsu_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);

  wfsu_pkg::in_item_t  in_item;
  wfsu_pkg::in_item_t  s1_r;
  logic                s1_valid_r;
  wfsu_pkg::out_item_t res;
  wfsu_pkg::out_item_t out_r;
  logic                out_valid_r;
  logic                two_pulse_mode;
  logic                advance;
  logic                fire;

  wfsu_apb u_apb (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .two_pulse_mode(two_pulse_mode)
  );

  always_comb begin
    in_item             = '0;
    in_item.mode        = in_tuser;
    in_item.frame_type  = in_tdata[7:0];
    in_item.board_index = in_tdata[9:8];
    in_item.card_index  = in_tdata[11:10];
    in_item.event_index = in_tdata[43:12];
    in_item.chip        = in_tdata[45:44];
    in_item.channel_in  = in_tdata[52:46];
    in_item.bucket_in   = in_tdata[61:53];
    in_item.sample_in   = in_tdata[73:62];
  end

  assign advance   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_r <= in_item;
    end
  end

  wfsu_proc u_proc (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .item          (s1_r),
    .two_pulse_mode(two_pulse_mode),
    .result        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {6'd0, out_r.first_in_channel, out_r.sample_out, out_r.bucket_out,
                       out_r.channel_out, out_r.chip_out, out_r.card_out,
                       out_r.decay_index};

endmodule
